// ===== hdl/cleb_pkg.sv =====
`timescale 1ns / 1ps

package cleb_pkg;

  // width of the text length and cursor counts
  localparam int COUNT_W = 7;

  // function codes on the input stream
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_MOVE   = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CHAR = 3'd1,
    ST_FULL     = 3'd2,
    ST_BAD_DIR  = 3'd3,
    ST_EDGE     = 3'd4
  } status_t;

  // direction bytes and character class bounds
  localparam logic [7:0] CH_LEFT    = 8'h6c;
  localparam logic [7:0] CH_RIGHT   = 8'h72;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_UNDER   = 8'd95;

  // letters and underscore only
  function automatic logic char_ok(input logic [7:0] c);
    char_ok = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
              ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
              (c == CH_UNDER);
  endfunction

endpackage

// ===== hdl/cleb_store.sv =====
`timescale 1ns / 1ps

module cleb_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/cursor_line_edit_buffer.sv =====
`timescale 1ns / 1ps

// channel  dir  signals                        contents
// s_       in   s_tvalid s_tready s_tdata     func, char_byte
// m_       out  m_tvalid m_tready m_tdata     status, out_char, text_length, cursor_position
//                       m_tuser m_tlast       out_valid, last
//
// Insert and delete go straight to the result, a cursor move reads then writes the store
// (states IDLE then MOVE), then the result is held until taken. Read out fetches each
// character (address in FETCH, registered store read into SEND), plus waiting on m_tready.
// Reset clears the counts and the sequencer; store contents stay undefined.
// s_tready is high only while no item is in work or waiting on the output.

module cursor_line_edit_buffer #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] func, [9:2] char_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [2:0] status, [10:3] out_char, [17:11] text_length,
                                 // [24:18] cursor_position
  output logic        m_tuser,   // [0] out_valid
  output logic        m_tlast
);

  localparam int CW = cleb_pkg::COUNT_W;
  localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MOVE  = 5'b00010,
    S_RESP  = 5'b00100,
    S_FETCH = 5'b01000,
    S_SEND  = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [CW-1:0]       before_count, before_count_next;
  logic [CW-1:0]       after_count, after_count_next;
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       gap, gap_next;
  logic                move_left, move_left_next;
  cleb_pkg::status_t   res_status, res_status_next;

  cleb_pkg::func_t     in_func;
  logic [7:0]          in_char;
  logic                in_fire;
  logic                out_fire;
  logic [CW-1:0]       total;
  logic                last_char;

  logic [CW-1:0]       agu_a, agu_b, agu_sum;
  logic                wr_en, rd_en;
  logic [7:0]          wr_data, rd_data;
  logic [7:0]          out_char;

  assign in_func   = cleb_pkg::func_t'(s_tdata[1:0]);
  assign in_char   = s_tdata[9:2];
  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;
  assign total     = before_count + after_count;
  assign last_char = ((idx + CW'(1)) == total);

  // shared address unit: one adder, operands picked by the sequencer
  always_comb begin
    agu_a = before_count;
    agu_b = '0;
    unique case (state)
      S_IDLE: begin
        if (in_func == cleb_pkg::FN_MOVE) begin
          if (in_char == cleb_pkg::CH_LEFT) begin
            agu_b = '1;
          end else begin
            agu_a = CAP_C;
            agu_b = -after_count;
          end
        end
      end
      S_MOVE: begin
        if (move_left) begin
          agu_a = CAP_C - CW'(1);
          agu_b = -after_count;
        end
      end
      S_FETCH: begin
        agu_a = idx;
        agu_b = (idx < before_count) ? '0 : gap;
      end
      default: begin
        agu_a = before_count;
        agu_b = '0;
      end
    endcase
  end

  assign agu_sum = agu_a + agu_b;

  // sequencer
  always_comb begin
    state_next        = state;
    before_count_next = before_count;
    after_count_next  = after_count;
    idx_next          = idx;
    gap_next          = gap;
    move_left_next    = move_left;
    res_status_next   = res_status;
    wr_en             = 1'b0;
    rd_en             = 1'b0;
    wr_data           = in_char;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          res_status_next = cleb_pkg::ST_OK;
          state_next      = S_RESP;
          unique case (in_func)
            cleb_pkg::FN_INSERT: begin
              if (!cleb_pkg::char_ok(in_char)) begin
                res_status_next = cleb_pkg::ST_BAD_CHAR;
              end else if (total >= CAP_C) begin
                res_status_next = cleb_pkg::ST_FULL;
              end else begin
                wr_en             = 1'b1;
                before_count_next = before_count + CW'(1);
              end
            end
            cleb_pkg::FN_DELETE: begin
              if (before_count == '0) begin
                res_status_next = cleb_pkg::ST_EDGE;
              end else begin
                before_count_next = before_count - CW'(1);
              end
            end
            cleb_pkg::FN_MOVE: begin
              if (in_char == cleb_pkg::CH_LEFT) begin
                if (before_count == '0) begin
                  res_status_next = cleb_pkg::ST_EDGE;
                end else begin
                  rd_en          = 1'b1;
                  move_left_next = 1'b1;
                  state_next     = S_MOVE;
                end
              end else if (in_char == cleb_pkg::CH_RIGHT) begin
                if (after_count == '0) begin
                  res_status_next = cleb_pkg::ST_EDGE;
                end else begin
                  rd_en          = 1'b1;
                  move_left_next = 1'b0;
                  state_next     = S_MOVE;
                end
              end else begin
                res_status_next = cleb_pkg::ST_BAD_DIR;
              end
            end
            cleb_pkg::FN_READ: begin
              if (total != '0) begin
                idx_next   = '0;
                gap_next   = CAP_C - total;
                state_next = S_FETCH;
              end
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      // copy the character across the gap
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
        if (move_left) begin
          before_count_next = before_count - CW'(1);
          after_count_next  = after_count + CW'(1);
        end else begin
          before_count_next = before_count + CW'(1);
          after_count_next  = after_count - CW'(1);
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_fire) begin
          state_next = S_IDLE;
        end
      end
      S_FETCH: begin
        rd_en      = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_fire) begin
          if (last_char) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = S_FETCH;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      before_count <= '0;
      after_count  <= '0;
      idx          <= '0;
    end else begin
      state        <= state_next;
      before_count <= before_count_next;
      after_count  <= after_count_next;
      idx          <= idx_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    gap        <= gap_next;
    move_left  <= move_left_next;
    res_status <= res_status_next;
  end

  cleb_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (agu_sum[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (agu_sum[AW-1:0]),
    .rd_data (rd_data)
  );

  // result transfer
  assign out_char = (state == S_SEND) ? rd_data : 8'd0;
  assign m_tvalid = (state == S_RESP) || (state == S_SEND);
  assign m_tuser  = (state == S_SEND);
  assign m_tlast  = (state == S_SEND) ? last_char : 1'b1;
  assign m_tdata  = {7'd0, before_count, total, out_char,
                     (state == S_SEND) ? cleb_pkg::ST_OK : res_status};

endmodule

// ===== bench/cursor_line_edit_buffer_tb.sv =====
`timescale 1ns / 1ps

module cursor_line_edit_buffer_tb;
  import cleb_pkg::*;

  localparam int TEXT_CAP      = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PRINT_CAP     = 40;

  // one expected transfer on the result stream
  typedef struct {
    status_t    status;
    logic       out_valid;
    logic [7:0] out_char;
    logic       last;
    logic [6:0] text_len;
    logic [6:0] cursor;
  } edit_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [1:0] func, [9:2] char_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [2:0] status, [10:3] out_char, [17:11] text_length,
                          // [24:18] cursor_position
  logic        m_tuser;   // [0] out_valid
  logic        m_tlast;

  // gap buffer mirror: text before the cursor from entry 0, text after it at the top
  logic [7:0]   text_mem [TEXT_CAP];
  int           before_len;
  int           after_len;
  edit_result_t pending_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int cycle_count;

  cursor_line_edit_buffer #(.CAPACITY(TEXT_CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic bit is_name_char(input logic [7:0] c);
    return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z], CH_UNDER};
  endfunction

  function automatic logic [7:0] rand_name_char();
    int pick;
    pick = $urandom_range(52);
    if (pick < 26)
      return CH_UPPER_A + 8'(pick);
    if (pick < 52)
      return CH_LOWER_A + 8'(pick - 26);
    return CH_UNDER;
  endfunction

  function automatic void push_result(input status_t st, input logic vld,
                                      input logic [7:0] ch, input logic fin);
    edit_result_t r;
    r.status    = st;
    r.out_valid = vld;
    r.out_char  = ch;
    r.last      = fin;
    r.text_len  = 7'(before_len + after_len);
    r.cursor    = 7'(before_len);
    pending_results.push_back(r);
  endfunction

  // apply one accepted command to the mirror and queue what it should produce
  function automatic void predict_edit(input func_t fn, input logic [7:0] ch);
    status_t st;
    int      total;
    int      idx;
    st = ST_OK;
    if (fn == FN_READ) begin
      total = before_len + after_len;
      if (total == 0)
        push_result(ST_OK, 1'b0, 8'd0, 1'b1);
      for (int i = 0; i < total; i++) begin
        idx = (i < before_len) ? i : TEXT_CAP - after_len + (i - before_len);
        push_result(ST_OK, 1'b1, text_mem[idx], i == total - 1);
      end
      return;
    end
    case (fn)
      FN_INSERT: begin
        if (!is_name_char(ch)) begin
          st = ST_BAD_CHAR;
        end else if (before_len + after_len >= TEXT_CAP) begin
          st = ST_FULL;
        end else begin
          text_mem[before_len] = ch;
          before_len++;
        end
      end
      FN_DELETE: begin
        if (before_len == 0)
          st = ST_EDGE;
        else
          before_len--;
      end
      default: begin
        if (ch == CH_LEFT) begin
          if (before_len == 0) begin
            st = ST_EDGE;
          end else begin
            text_mem[TEXT_CAP - after_len - 1] = text_mem[before_len - 1];
            before_len--;
            after_len++;
          end
        end else if (ch == CH_RIGHT) begin
          if (after_len == 0) begin
            st = ST_EDGE;
          end else begin
            text_mem[before_len] = text_mem[TEXT_CAP - after_len];
            before_len++;
            after_len--;
          end
        end else begin
          st = ST_BAD_DIR;
        end
      end
    endcase
    push_result(st, 1'b0, 8'd0, 1'b1);
  endfunction

  // one command transfer, with random idle cycles ahead of it
  task automatic send_item(input func_t fn, input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, ch, fn};
    do @(posedge clk); while (!s_tready);
    predict_edit(fn, ch);
  endtask

  // hold off until every queued result has been taken
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_result();
    edit_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected transfer tdata=%h tuser=%b tlast=%b",
                                m_tdata, m_tuser, m_tlast));
      return;
    end
    want = pending_results.pop_front();
    if (m_tdata[2:0] !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", m_tdata[2:0], want.status));
    if (m_tuser !== want.out_valid)
      report_mismatch($sformatf("out_valid %b, want %b", m_tuser, want.out_valid));
    if (m_tdata[10:3] !== want.out_char)
      report_mismatch($sformatf("out_char %h, want %h", m_tdata[10:3], want.out_char));
    if (m_tlast !== want.last)
      report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
    if (m_tdata[17:11] !== want.text_len)
      report_mismatch($sformatf("text_length %0d, want %0d", m_tdata[17:11], want.text_len));
    if (m_tdata[24:18] !== want.cursor)
      report_mismatch($sformatf("cursor_position %0d, want %0d", m_tdata[24:18],
                                want.cursor));
  endtask

  // result side: random back-pressure and checking of each transfer
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready)
      check_result();
  end

  // edges of an empty buffer, bad directions, read of empty text
  task automatic test_empty_edges();
    send_item(FN_READ, 8'h00);
    send_item(FN_DELETE, 8'h00);
    send_item(FN_MOVE, CH_LEFT);
    send_item(FN_MOVE, CH_RIGHT);
    send_item(FN_MOVE, 8'h00);
    send_item(FN_MOVE, 8'hff);
    send_item(FN_READ, 8'hff);
  endtask

  // character class boundaries on insert
  task automatic test_char_classes();
    send_item(FN_INSERT, 8'h00);
    send_item(FN_INSERT, CH_UPPER_A - 8'd1);
    send_item(FN_INSERT, CH_UPPER_Z + 8'd1);
    send_item(FN_INSERT, CH_LOWER_A - 8'd1);
    send_item(FN_INSERT, CH_LOWER_Z + 8'd1);
    send_item(FN_INSERT, 8'hff);
    send_item(FN_INSERT, CH_UPPER_A);
    send_item(FN_INSERT, CH_UPPER_Z);
    send_item(FN_INSERT, CH_LOWER_A);
    send_item(FN_INSERT, CH_LOWER_Z);
    send_item(FN_INSERT, CH_UNDER);
    send_item(FN_READ, 8'h00);
  endtask

  // edit in the middle of the text and run into the right edge
  task automatic test_cursor_moves();
    send_item(FN_MOVE, CH_LEFT);
    send_item(FN_MOVE, CH_LEFT);
    send_item(FN_INSERT, CH_LOWER_A + 8'd12);
    send_item(FN_MOVE, CH_RIGHT);
    send_item(FN_DELETE, 8'h00);
    send_item(FN_MOVE, CH_RIGHT);
    send_item(FN_MOVE, CH_RIGHT);
    send_item(FN_READ, 8'h00);
  endtask

  // fill the store with random text, then hit the full case
  task automatic test_fill_to_capacity();
    while (before_len + after_len < TEXT_CAP) begin
      if (before_len > 0 && $urandom_range(9) == 0)
        send_item(FN_MOVE, CH_LEFT);
      else
        send_item(FN_INSERT, rand_name_char());
    end
    send_item(FN_INSERT, rand_name_char());
    send_item(FN_INSERT, CH_UPPER_A - 8'd1);
    send_item(FN_MOVE, CH_RIGHT);
    send_item(FN_READ, 8'h00);
  endtask

  // random mix of edits, reads and malformed commands
  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input int n_items);
    int pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 25)
        send_item(FN_INSERT, rand_name_char());
      else if (pick < 30)
        send_item(FN_INSERT, 8'($urandom_range(255)));
      else if (pick < 65)
        send_item(FN_DELETE, 8'($urandom_range(255)));
      else if (pick < 85)
        send_item(FN_MOVE, $urandom_range(1) ? CH_LEFT : CH_RIGHT);
      else if (pick < 90)
        send_item(FN_MOVE, 8'($urandom_range(255)));
      else
        send_item(FN_READ, 8'($urandom_range(255)));
    end
    wait_for_results();
  endtask

  initial begin
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= 16'd0;
    m_tready       <= 1'b0;
    before_len     = 0;
    after_len      = 0;
    mismatches     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_edges();
    test_char_classes();
    test_cursor_moves();
    wait_for_results();

    send_idle_pct  = 13;
    recv_stall_pct = 13;
    test_fill_to_capacity();
    wait_for_results();

    test_random_phase(0, 0, 13);
    test_random_phase(69, 0, 13);
    test_random_phase(0, 69, 13);
    test_random_phase(13, 13, 13);

    // let any stray transfer show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
